FILE: design/tled_pkg.sv
// ----------------------------------------------------------------------------
// tled_pkg
// Shared constants, codes and types of the two-level event dispatch block.
// ----------------------------------------------------------------------------
package tled_pkg;

  localparam int NUM_PORTS = 4096;
  localparam int WORD_BITS = 64;
  localparam int NUM_CPUS  = 4;

  localparam int PORT_W   = 12;
  localparam int CPU_W    = 2;
  localparam int WORD_W   = 6;
  localparam int ACTION_W = 4;

  localparam int ADDR_W = $clog2(NUM_PORTS);
  localparam int SPAN_W = PORT_W + 1;
  localparam int BCNT_W = $clog2(WORD_BITS + 1);

  typedef enum logic [ACTION_W-1:0] {
    ACT_RAISE       = 4'd0,
    ACT_MASK        = 4'd1,
    ACT_UNMASK      = 4'd2,
    ACT_CLEAR       = 4'd3,
    ACT_BIND        = 4'd4,
    ACT_UNBIND      = 4'd5,
    ACT_SET_OWNER   = 4'd6,
    ACT_READ_MISSED = 4'd7,
    ACT_CLOSE       = 4'd8,
    ACT_SERVICE     = 4'd9
  } action_t;

  typedef enum logic [1:0] {
    KIND_ACK       = 2'd0,
    KIND_DELIVERED = 2'd1,
    KIND_MISSED    = 2'd2,
    KIND_IDLE      = 2'd3
  } kind_t;

  typedef struct packed {
    logic             pending;
    logic             mask;
    logic [CPU_W-1:0] owner;
    logic             bound;
    logic             missed;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

  typedef struct packed {
    logic [PORT_W-1:0] port;
    kind_t             kind;
    logic              missed;
    logic              last;
  } res_t;

endpackage

FILE: design/tled_ram.sv
// ----------------------------------------------------------------------------
// tled_ram
// Generic single-write, single-read memory with a registered read port.
// ----------------------------------------------------------------------------
module tled_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

FILE: design/tled_obuf.sv
// ----------------------------------------------------------------------------
// tled_obuf
// Output register that holds one result until the consumer takes it.
// ----------------------------------------------------------------------------
module tled_obuf
  import tled_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  input  res_t              res,
  output logic              ready,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [PORT_W-1:0] result_port,
  output logic [1:0]        kind,
  output logic              missed_flag,
  output logic              last
);

  logic full;
  res_t data;

  assign ready = !full || !out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      full <= 1'b0;
    end else if (push) begin
      full <= 1'b1;
    end else if (!out_stall) begin
      full <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      data <= res;
    end
  end

  assign out_valid   = full;
  assign result_port = data.port;
  assign kind        = data.kind;
  assign missed_flag = data.missed;
  assign last        = data.last;

endmodule

FILE: design/tled_ctrl.sv
// ----------------------------------------------------------------------------
// tled_ctrl
// Sequencer that clears the port table, applies port actions and scans one
// pending word per service request, one port at a time.
// ----------------------------------------------------------------------------
module tled_ctrl
  import tled_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  input  logic                accept,
  input  logic [ACTION_W-1:0] action,
  input  logic [PORT_W-1:0]   port,
  input  logic [CPU_W-1:0]    cpu,
  input  logic [WORD_W-1:0]   word_index,
  output logic                idle,
  output logic                ram_wr_en,
  output logic [ADDR_W-1:0]   ram_wr_addr,
  output logic [ENTRY_W-1:0]  ram_wr_data,
  output logic                ram_rd_en,
  output logic [ADDR_W-1:0]   ram_rd_addr,
  input  logic [ENTRY_W-1:0]  ram_rd_data,
  input  logic                out_ready,
  output logic                push,
  output res_t                res
);

  typedef enum logic [5:0] {
    ST_CLEAR   = 6'b000001,
    ST_IDLE    = 6'b000010,
    ST_ACT     = 6'b000100,
    ST_SCAN_RD = 6'b001000,
    ST_SCAN_EV = 6'b010000,
    ST_FINISH  = 6'b100000
  } state_t;

  state_t              state, state_next;
  logic [ADDR_W-1:0]   clr_addr, clr_addr_next;
  logic [ACTION_W-1:0] req_action, req_action_next;
  logic [PORT_W-1:0]   req_port, req_port_next;
  logic [CPU_W-1:0]    req_cpu, req_cpu_next;
  logic [SPAN_W-1:0]   p_cur, p_cur_next;
  logic [BCNT_W-1:0]   b_cnt, b_cnt_next;
  res_t                held, held_next;
  logic                held_valid, held_valid_next;

  entry_t rd_entry;
  entry_t new_entry;
  logic   port_ok;
  logic   cpu_ok;
  logic   eligible;
  logic   scan_done;

  assign rd_entry  = entry_t'(ram_rd_data);
  assign port_ok   = int'(req_port) < NUM_PORTS;
  assign cpu_ok    = int'(req_cpu) < NUM_CPUS;
  assign eligible  = rd_entry.pending && !rd_entry.mask && (rd_entry.owner == req_cpu);
  assign scan_done = (b_cnt == BCNT_W'(WORD_BITS)) || (int'(p_cur) >= NUM_PORTS) || !cpu_ok;
  assign idle      = (state == ST_IDLE);

  always_comb begin
    new_entry = rd_entry;
    case (req_action)
      ACT_RAISE:       new_entry.pending = 1'b1;
      ACT_MASK:        new_entry.mask = 1'b1;
      ACT_UNMASK:      new_entry.mask = 1'b0;
      ACT_CLEAR:       new_entry.pending = 1'b0;
      ACT_BIND:        new_entry.bound = 1'b1;
      ACT_UNBIND: begin
        new_entry.bound  = 1'b0;
        new_entry.missed = 1'b0;
      end
      ACT_SET_OWNER: begin
        if (cpu_ok) begin
          new_entry.owner = req_cpu;
        end
      end
      ACT_READ_MISSED: new_entry.missed = 1'b0;
      ACT_CLOSE: begin
        new_entry.pending = 1'b0;
        new_entry.mask    = 1'b1;
        new_entry.owner   = '0;
        new_entry.bound   = 1'b0;
        new_entry.missed  = 1'b0;
      end
      default: new_entry = rd_entry;
    endcase
  end

  always_comb begin
    state_next      = state;
    clr_addr_next   = clr_addr;
    req_action_next = req_action;
    req_port_next   = req_port;
    req_cpu_next    = req_cpu;
    p_cur_next      = p_cur;
    b_cnt_next      = b_cnt;
    held_next       = held;
    held_valid_next = held_valid;
    ram_wr_en       = 1'b0;
    ram_wr_addr     = clr_addr;
    ram_wr_data     = '0;
    ram_rd_en       = 1'b0;
    ram_rd_addr     = port[ADDR_W-1:0];
    push            = 1'b0;
    res             = held;

    case (state)
      ST_CLEAR: begin
        ram_wr_en     = 1'b1;
        clr_addr_next = clr_addr + 1'b1;
        if (clr_addr == ADDR_W'(NUM_PORTS - 1)) begin
          state_next = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (accept) begin
          req_action_next = action;
          req_port_next   = port;
          req_cpu_next    = cpu;
          p_cur_next      = SPAN_W'(word_index) * SPAN_W'(WORD_BITS);
          b_cnt_next      = '0;
          held_valid_next = 1'b0;
          if (action == ACT_SERVICE) begin
            state_next = ST_SCAN_RD;
          end else begin
            ram_rd_en  = 1'b1;
            state_next = ST_ACT;
          end
        end
      end
      ST_ACT: begin
        if (out_ready) begin
          ram_wr_en   = port_ok && (req_action inside {[ACT_RAISE:ACT_CLOSE]});
          ram_wr_addr = req_port[ADDR_W-1:0];
          ram_wr_data = new_entry;
          push        = 1'b1;
          res.port    = req_port;
          res.kind    = KIND_ACK;
          res.missed  = port_ok && (req_action == ACT_READ_MISSED) && rd_entry.missed;
          res.last    = 1'b1;
          state_next  = ST_IDLE;
        end
      end
      ST_SCAN_RD: begin
        if (scan_done) begin
          state_next = ST_FINISH;
        end else begin
          ram_rd_en   = 1'b1;
          ram_rd_addr = p_cur[ADDR_W-1:0];
          state_next  = ST_SCAN_EV;
        end
      end
      ST_SCAN_EV: begin
        if (!eligible) begin
          p_cur_next = p_cur + 1'b1;
          b_cnt_next = b_cnt + 1'b1;
          state_next = ST_SCAN_RD;
        end else if (!held_valid || out_ready) begin
          push                = held_valid;
          ram_wr_en           = 1'b1;
          ram_wr_addr         = p_cur[ADDR_W-1:0];
          ram_wr_data         = rd_entry;
          ram_wr_data[ENTRY_W-1] = 1'b0;
          if (!rd_entry.bound) begin
            ram_wr_data[0] = 1'b1;
          end
          held_next.port   = p_cur[PORT_W-1:0];
          held_next.kind   = rd_entry.bound ? KIND_DELIVERED : KIND_MISSED;
          held_next.missed = 1'b0;
          held_next.last   = 1'b0;
          held_valid_next  = 1'b1;
          p_cur_next       = p_cur + 1'b1;
          b_cnt_next       = b_cnt + 1'b1;
          state_next       = ST_SCAN_RD;
        end
      end
      ST_FINISH: begin
        if (out_ready) begin
          push = 1'b1;
          if (held_valid) begin
            res.last = 1'b1;
          end else begin
            res.port   = '0;
            res.kind   = KIND_IDLE;
            res.missed = 1'b0;
            res.last   = 1'b1;
          end
          held_valid_next = 1'b0;
          state_next      = ST_IDLE;
        end
      end
      default: state_next = ST_CLEAR;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_CLEAR;
      clr_addr   <= '0;
      held_valid <= 1'b0;
    end else begin
      state      <= state_next;
      clr_addr   <= clr_addr_next;
      held_valid <= held_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    req_action <= req_action_next;
    req_port   <= req_port_next;
    req_cpu    <= req_cpu_next;
    p_cur      <= p_cur_next;
    b_cnt      <= b_cnt_next;
    held       <= held_next;
  end

endmodule

FILE: design/two_level_event_dispatch.sv
// ----------------------------------------------------------------------------
// two_level_event_dispatch
// Event-port controller: per-port pending, mask, owner, bound and missed
// state, with port actions and one-word dispatch for a serving CPU.
// ----------------------------------------------------------------------------
//  channel | handshake          | payload
//  --------+--------------------+------------------------------------------
//  in      | in_valid/in_stall  | action, port, cpu, word_index
//  out     | out_valid/out_stall| result_port, kind, missed_flag, last
//
// After reset the port table is cleared one entry per cycle while in_stall is
// high. A port action reads its port table entry, then writes back the
// updated entry; unknown action codes write nothing. A service request reads
// and checks each port of the word in turn, then sends a final result.
// A stalled output holds the sequencer until its result can be registered.
// ----------------------------------------------------------------------------
module two_level_event_dispatch
  import tled_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_stall,
  input  logic [ACTION_W-1:0] action,
  input  logic [PORT_W-1:0]   port,
  input  logic [CPU_W-1:0]    cpu,
  input  logic [WORD_W-1:0]   word_index,
  output logic                out_valid,
  input  logic                out_stall,
  output logic [PORT_W-1:0]   result_port,
  output logic [1:0]          kind,
  output logic                missed_flag,
  output logic                last
);

  logic               idle;
  logic               ram_wr_en;
  logic [ADDR_W-1:0]  ram_wr_addr;
  logic [ENTRY_W-1:0] ram_wr_data;
  logic               ram_rd_en;
  logic [ADDR_W-1:0]  ram_rd_addr;
  logic [ENTRY_W-1:0] ram_rd_data;
  logic               out_ready;
  logic               push;
  res_t               res;

  assign in_stall = !idle;

  tled_ram #(
    .WIDTH(ENTRY_W),
    .DEPTH(NUM_PORTS)
  ) u_ram (
    .clk     (clk),
    .wr_en   (ram_wr_en),
    .wr_addr (ram_wr_addr),
    .wr_data (ram_wr_data),
    .rd_en   (ram_rd_en),
    .rd_addr (ram_rd_addr),
    .rd_data (ram_rd_data)
  );

  tled_ctrl u_ctrl (
    .clk         (clk),
    .rst         (rst),
    .accept      (in_valid && idle),
    .action      (action),
    .port        (port),
    .cpu         (cpu),
    .word_index  (word_index),
    .idle        (idle),
    .ram_wr_en   (ram_wr_en),
    .ram_wr_addr (ram_wr_addr),
    .ram_wr_data (ram_wr_data),
    .ram_rd_en   (ram_rd_en),
    .ram_rd_addr (ram_rd_addr),
    .ram_rd_data (ram_rd_data),
    .out_ready   (out_ready),
    .push        (push),
    .res         (res)
  );

  tled_obuf u_obuf (
    .clk         (clk),
    .rst         (rst),
    .push        (push),
    .res         (res),
    .ready       (out_ready),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .result_port (result_port),
    .kind        (kind),
    .missed_flag (missed_flag),
    .last        (last)
  );

endmodule

FILE: bench/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the two-level event dispatch block. Directed
// requests walk through every port action, masking, ownership, the missed
// flag, close, unknown action codes and empty service words; random traffic
// then builds pending words and services them. Each accepted request is run
// through a port-table predictor and every result is checked in order, with
// random idling on both sides.
// ----------------------------------------------------------------------------
module tb
  import tled_pkg::*;
();

  localparam int WATCHDOG_LIMIT = 20000;
  localparam int RANDOM_REQUESTS = 135;

  logic                clk = 1'b0;
  logic                rst = 1'b1;
  logic                in_valid = 1'b0;
  logic                in_stall;
  logic [ACTION_W-1:0] action = '0;
  logic [PORT_W-1:0]   port = '0;
  logic [CPU_W-1:0]    cpu = '0;
  logic [WORD_W-1:0]   word_index = '0;
  logic                out_valid;
  logic                out_stall = 1'b0;
  logic [PORT_W-1:0]   result_port;
  logic [1:0]          kind;
  logic                missed_flag;
  logic                last;

  logic             pend_st   [NUM_PORTS];
  logic             mask_st   [NUM_PORTS];
  logic [CPU_W-1:0] owner_st  [NUM_PORTS];
  logic             bound_st  [NUM_PORTS];
  logic             missed_st [NUM_PORTS];

  res_t event_results_q[$];
  res_t head_r;
  int   fail_count = 0;
  int   sent_count = 0;
  int   quiet_cycles = 0;
  bit   idle_on = 1'b1;

  two_level_event_dispatch dut (.*);

  always #5 clk = ~clk;

  // Updates the port table for one accepted request and queues its results.
  function automatic void apply_event_request(logic [ACTION_W-1:0] a, logic [PORT_W-1:0] p,
                                              logic [CPU_W-1:0] c, logic [WORD_W-1:0] w);
    res_t r;
    res_t held;
    bit   have;
    int   q;
    int   b;
    have = 1'b0;
    if (a == ACT_SERVICE) begin
      if (int'(c) < NUM_CPUS) begin
        for (b = 0; b < WORD_BITS; b++) begin
          q = int'(w) * WORD_BITS + b;
          if (q >= NUM_PORTS) break;
          if (pend_st[q] && !mask_st[q] && owner_st[q] == c) begin
            pend_st[q] = 1'b0;
            r.port = q[PORT_W-1:0];
            r.kind = bound_st[q] ? KIND_DELIVERED : KIND_MISSED;
            r.missed = 1'b0;
            r.last = 1'b0;
            if (!bound_st[q]) missed_st[q] = 1'b1;
            if (have) event_results_q.push_back(held);
            held = r;
            have = 1'b1;
          end
        end
      end
      if (have) begin
        held.last = 1'b1;
        event_results_q.push_back(held);
      end else begin
        r.port = '0;
        r.kind = KIND_IDLE;
        r.missed = 1'b0;
        r.last = 1'b1;
        event_results_q.push_back(r);
      end
    end else begin
      r.port = p;
      r.kind = KIND_ACK;
      r.missed = 1'b0;
      r.last = 1'b1;
      if (int'(p) < NUM_PORTS) begin
        case (a)
          ACT_RAISE: pend_st[p] = 1'b1;
          ACT_MASK: mask_st[p] = 1'b1;
          ACT_UNMASK: mask_st[p] = 1'b0;
          ACT_CLEAR: pend_st[p] = 1'b0;
          ACT_BIND: bound_st[p] = 1'b1;
          ACT_UNBIND: begin
            bound_st[p] = 1'b0;
            missed_st[p] = 1'b0;
          end
          ACT_SET_OWNER: begin
            if (int'(c) < NUM_CPUS) owner_st[p] = c;
          end
          ACT_READ_MISSED: begin
            r.missed = missed_st[p];
            missed_st[p] = 1'b0;
          end
          ACT_CLOSE: begin
            mask_st[p] = 1'b1;
            pend_st[p] = 1'b0;
            bound_st[p] = 1'b0;
            missed_st[p] = 1'b0;
            owner_st[p] = '0;
          end
          default: ;
        endcase
      end
      event_results_q.push_back(r);
    end
  endfunction

  task automatic send_request(logic [ACTION_W-1:0] a, logic [PORT_W-1:0] p,
                              logic [CPU_W-1:0] c, logic [WORD_W-1:0] w);
    while (idle_on && $urandom_range(0, 99) < 11) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    action <= a;
    port <= p;
    cpu <= c;
    word_index <= w;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    apply_event_request(a, p, c, w);
    sent_count++;
  endtask

  task automatic send_port_action(logic [ACTION_W-1:0] a, logic [PORT_W-1:0] p);
    send_request(a, p, CPU_W'($urandom), WORD_W'($urandom));
  endtask

  task automatic send_service(logic [WORD_W-1:0] w, logic [CPU_W-1:0] c);
    send_request(ACT_SERVICE, PORT_W'($urandom), c, w);
  endtask

  task automatic test_service_edges();
    send_port_action(ACT_RAISE, 12'd0);
    send_service(6'd0, 2'd0);
    send_port_action(ACT_BIND, 12'd4095);
    send_port_action(ACT_RAISE, 12'd4095);
    send_port_action(ACT_MASK, 12'd4095);
    send_service(6'd63, 2'd0);
    send_port_action(ACT_UNMASK, 12'd4095);
    send_request(ACT_SET_OWNER, 12'd4095, 2'd3, 6'd0);
    send_service(6'd63, 2'd3);
  endtask

  task automatic test_missed_flag();
    send_port_action(ACT_READ_MISSED, 12'd0);
    send_port_action(ACT_READ_MISSED, 12'd0);
    send_port_action(ACT_RAISE, 12'd63);
    send_port_action(ACT_CLEAR, 12'd63);
    send_service(6'd0, 2'd0);
    send_port_action(ACT_RAISE, 12'd1);
    send_service(6'd0, 2'd0);
    send_port_action(ACT_UNBIND, 12'd1);
    send_port_action(ACT_READ_MISSED, 12'd1);
  endtask

  task automatic test_close();
    send_port_action(ACT_BIND, 12'd2);
    send_request(ACT_SET_OWNER, 12'd2, 2'd1, 6'd63);
    send_port_action(ACT_RAISE, 12'd2);
    send_port_action(ACT_CLOSE, 12'd2);
    send_service(6'd0, 2'd1);
  endtask

  task automatic test_unknown_actions();
    send_request(4'd10, 12'd4095, 2'd3, 6'd63);
    send_request(4'd13, 12'd2730, 2'd1, 6'd21);
    send_request(4'd15, 12'd1365, 2'd2, 6'd42);
  endtask

  // Prepares a few ports of one word, then services that word.
  task automatic run_dispatch_sequence();
    logic [WORD_W-1:0] w;
    logic [CPU_W-1:0]  c;
    logic [PORT_W-1:0] p;
    int                k;
    int                i;
    case ($urandom_range(0, 5))
      0: w = 6'd0;
      1: w = 6'd1;
      2: w = 6'd31;
      3: w = 6'd62;
      4: w = 6'd63;
      default: w = WORD_W'($urandom);
    endcase
    c = CPU_W'($urandom);
    k = $urandom_range(1, 5);
    p = '0;
    for (i = 0; i < k; i++) begin
      p = {w, 6'($urandom_range(0, 63))};
      if ($urandom_range(0, 99) < 40) send_request(ACT_SET_OWNER, p, c, WORD_W'($urandom));
      if ($urandom_range(0, 99) < 40) send_port_action(ACT_BIND, p);
      if ($urandom_range(0, 99) < 15) send_port_action(ACT_UNBIND, p);
      if ($urandom_range(0, 99) < 25) send_port_action(ACT_UNMASK, p);
      if ($urandom_range(0, 99) < 10) send_port_action(ACT_MASK, p);
      if ($urandom_range(0, 99) < 90) send_port_action(ACT_RAISE, p);
    end
    if ($urandom_range(0, 99) < 85) send_service(w, c);
    else send_service(w, CPU_W'($urandom));
    if ($urandom_range(0, 99) < 40) send_port_action(ACT_READ_MISSED, p);
  endtask

  task automatic test_random_traffic();
    int start;
    int b;
    start = sent_count;
    for (b = 0; b < WORD_BITS; b++) send_port_action(ACT_RAISE, {6'd62, 6'(b)});
    send_service(6'd62, 2'd0);
    while (sent_count - start < RANDOM_REQUESTS) begin
      idle_on = !((sent_count - start) >= 70 && (sent_count - start) < 120);
      if ($urandom_range(0, 99) < 75) run_dispatch_sequence();
      else send_request(ACTION_W'($urandom), PORT_W'($urandom), CPU_W'($urandom),
                        WORD_W'($urandom));
    end
    idle_on = 1'b1;
  endtask

  always @(posedge clk) begin
    out_stall <= idle_on && ($urandom_range(0, 99) < 11);
  end

  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      if (event_results_q.size() == 0) begin
        $display("%0t: unexpected result port %0d kind %0d missed %0b last %0b",
                 $time, result_port, kind, missed_flag, last);
        fail_count++;
      end else begin
        head_r = event_results_q.pop_front();
        if ({result_port, kind, missed_flag, last} !== head_r) begin
          $display({"%0t: expected port %0d kind %0d missed %0b last %0b, ",
                    "actual port %0d kind %0d missed %0b last %0b"},
                   $time, head_r.port, head_r.kind, head_r.missed, head_r.last,
                   result_port, kind, missed_flag, last);
          fail_count++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("tb NOT OK");
      $finish;
    end
  end

  initial begin
    foreach (pend_st[i]) begin
      pend_st[i] = 1'b0;
      mask_st[i] = 1'b0;
      owner_st[i] = '0;
      bound_st[i] = 1'b0;
      missed_st[i] = 1'b0;
    end
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    test_service_edges();
    test_missed_flag();
    test_close();
    test_unknown_actions();
    test_random_traffic();
    in_valid <= 1'b0;
    while (event_results_q.size() != 0) @(posedge clk);
    repeat (300) @(posedge clk);
    if (fail_count == 0) begin
      $display("tb OK");
    end else begin
      $display("tb NOT OK");
    end
    $finish;
  end

endmodule

FILE: files.f
design/tled_pkg.sv
design/tled_ram.sv
design/tled_obuf.sv
design/tled_ctrl.sv
design/two_level_event_dispatch.sv
bench/tb.sv
